### sv/ptpm_pkg.sv
package ptpm_pkg;

    localparam int ENTRIES_DEF       = 64;
    localparam int DATA_BITS_DEF     = 32;
    localparam int PRIORITY_BITS_DEF = 16;

    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_PROMOTE  = 3'd1;
    localparam logic [2:0] OP_GET_MAX  = 3'd2;
    localparam logic [2:0] OP_POP_MAX  = 3'd3;
    localparam logic [2:0] OP_IS_VALID = 3'd4;
    localparam logic [2:0] OP_GET      = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEAD  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

endpackage

### sv/priority_table_pop_max.sv
// A table of ENTRIES payload words with priorities, kept in a row of cells, one entry per
// cell. Every word runs a token once along the whole row, one cell per clock, which
// gathers the maximum or the addressed entry; the result is then registered, and the
// word waits in the push state until the output register is free, so no new word is
// accepted before the last one's result has moved there. A new word is taken while the
// previous result still waits on the result channel. Ids are handed out in increasing
// order and never reused, so the entries need no clearing after reset.
module priority_table_pop_max
    import ptpm_pkg::*;
#(
    parameter int ENTRIES       = ENTRIES_DEF,
    parameter int DATA_BITS     = DATA_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    localparam int ID_BITS      = $clog2(ENTRIES)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_opcode,
    input  logic [ID_BITS-1:0]       s_item_id,
    input  logic [DATA_BITS-1:0]     s_object_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic [ID_BITS-1:0]       m_result_id,
    output logic [DATA_BITS-1:0]     m_result_data,
    output logic [PRIORITY_BITS-1:0] m_result_priority,
    output logic                     m_id_live
);

    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic                     start_reg, start_next;
    logic [2:0]               op_reg;
    logic [ID_BITS-1:0]       id_reg;
    logic [DATA_BITS-1:0]     data_reg;
    logic [CNT_BITS-1:0]      fill_reg, fill_next;

    logic [1:0]               res_status_reg, res_status_next;
    logic [ID_BITS-1:0]       res_id_reg, res_id_next;
    logic [DATA_BITS-1:0]     res_data_reg, res_data_next;
    logic [PRIORITY_BITS-1:0] res_prio_reg, res_prio_next;
    logic                     res_live_reg, res_live_next;

    logic                     m_valid_reg, m_valid_next;
    logic [1:0]               m_status_reg;
    logic [ID_BITS-1:0]       m_id_reg;
    logic [DATA_BITS-1:0]     m_data_reg;
    logic [PRIORITY_BITS-1:0] m_prio_reg;
    logic                     m_live_reg;

    logic                     retire_valid;
    logic [ID_BITS-1:0]       retire_id;
    logic                     out_free;

    logic                     t_valid     [ENTRIES+1];
    logic                     t_found     [ENTRIES+1];
    logic [ID_BITS-1:0]       t_best_id   [ENTRIES+1];
    logic [PRIORITY_BITS-1:0] t_best_prio [ENTRIES+1];
    logic [DATA_BITS-1:0]     t_best_data [ENTRIES+1];
    logic                     t_hit_live  [ENTRIES+1];
    logic [DATA_BITS-1:0]     t_hit_data  [ENTRIES+1];
    logic [PRIORITY_BITS-1:0] t_hit_prio  [ENTRIES+1];

    assign t_valid[0]     = start_reg;
    assign t_found[0]     = 1'b0;
    assign t_best_id[0]   = '0;
    assign t_best_prio[0] = '0;
    assign t_best_data[0] = '0;
    assign t_hit_live[0]  = 1'b0;
    assign t_hit_data[0]  = '0;
    assign t_hit_prio[0]  = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_row
        ptpm_cell #(
            .IDX           (i),
            .ENTRIES       (ENTRIES),
            .DATA_BITS     (DATA_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cmd_op        (op_reg),
            .cmd_id        (id_reg),
            .cmd_data      (data_reg),
            .fill          (fill_reg),
            .retire_valid  (retire_valid),
            .retire_id     (retire_id),
            .in_valid      (t_valid[i]),
            .in_found      (t_found[i]),
            .in_best_id    (t_best_id[i]),
            .in_best_prio  (t_best_prio[i]),
            .in_best_data  (t_best_data[i]),
            .in_hit_live   (t_hit_live[i]),
            .in_hit_data   (t_hit_data[i]),
            .in_hit_prio   (t_hit_prio[i]),
            .out_valid     (t_valid[i+1]),
            .out_found     (t_found[i+1]),
            .out_best_id   (t_best_id[i+1]),
            .out_best_prio (t_best_prio[i+1]),
            .out_best_data (t_best_data[i+1]),
            .out_hit_live  (t_hit_live[i+1]),
            .out_hit_data  (t_hit_data[i+1]),
            .out_hit_prio  (t_hit_prio[i+1])
        );
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign retire_id = t_best_id[ENTRIES];
    assign retire_valid = (state_reg == S_RUN) && t_valid[ENTRIES]
                          && (op_reg == OP_POP_MAX) && t_found[ENTRIES];

    always_comb begin
        state_next      = state_reg;
        start_next      = 1'b0;
        fill_next       = fill_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_data_next   = res_data_reg;
        res_prio_next   = res_prio_reg;
        res_live_next   = res_live_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    start_next = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (t_valid[ENTRIES]) begin
                    res_status_next = ST_OK;
                    res_id_next     = '0;
                    res_data_next   = '0;
                    res_prio_next   = '0;
                    res_live_next   = 1'b0;
                    case (op_reg) inside
                        OP_ADD: begin
                            if (fill_reg >= FULL_CNT) begin
                                res_status_next = ST_FULL;
                            end else begin
                                res_id_next   = fill_reg[ID_BITS-1:0];
                                res_live_next = 1'b1;
                                fill_next     = fill_reg + 1'b1;
                            end
                        end
                        OP_PROMOTE: begin
                            if (!t_hit_live[ENTRIES]) begin
                                res_status_next = ST_DEAD;
                            end else begin
                                res_id_next   = id_reg;
                                res_prio_next = t_hit_prio[ENTRIES];
                                res_live_next = 1'b1;
                            end
                        end
                        OP_GET_MAX, OP_POP_MAX: begin
                            if (!t_found[ENTRIES]) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                res_id_next   = t_best_id[ENTRIES];
                                res_data_next = t_best_data[ENTRIES];
                                res_prio_next = t_best_prio[ENTRIES];
                                res_live_next = (op_reg == OP_GET_MAX);
                            end
                        end
                        OP_IS_VALID: begin
                            res_id_next   = id_reg;
                            res_live_next = t_hit_live[ENTRIES];
                        end
                        OP_GET: begin
                            if (!t_hit_live[ENTRIES]) begin
                                res_status_next = ST_DEAD;
                            end else begin
                                res_id_next   = id_reg;
                                res_data_next = t_hit_data[ENTRIES];
                                res_live_next = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_data_reg   <= res_data_next;
        res_prio_reg   <= res_prio_next;
        res_live_reg   <= res_live_next;
        if (state_reg == S_IDLE && s_valid) begin
            op_reg   <= s_opcode;
            id_reg   <= s_item_id;
            data_reg <= s_object_data;
        end
        if (state_reg == S_PUSH && out_free) begin
            m_status_reg <= res_status_reg;
            m_id_reg     <= res_id_reg;
            m_data_reg   <= res_data_reg;
            m_prio_reg   <= res_prio_reg;
            m_live_reg   <= res_live_reg;
        end
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            start_reg   <= 1'b0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_result_id       = m_id_reg;
    assign m_result_data     = m_data_reg;
    assign m_result_priority = m_prio_reg;
    assign m_id_live         = m_live_reg;

endmodule

### sv/ptpm_cell.sv
module ptpm_cell
    import ptpm_pkg::*;
#(
    parameter int IDX           = 0,
    parameter int ENTRIES       = ENTRIES_DEF,
    parameter int DATA_BITS     = DATA_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    localparam int ID_BITS      = $clog2(ENTRIES),
    localparam int CNT_BITS     = $clog2(ENTRIES + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [2:0]               cmd_op,
    input  logic [ID_BITS-1:0]       cmd_id,
    input  logic [DATA_BITS-1:0]     cmd_data,
    input  logic [CNT_BITS-1:0]      fill,
    input  logic                     retire_valid,
    input  logic [ID_BITS-1:0]       retire_id,
    input  logic                     in_valid,
    input  logic                     in_found,
    input  logic [ID_BITS-1:0]       in_best_id,
    input  logic [PRIORITY_BITS-1:0] in_best_prio,
    input  logic [DATA_BITS-1:0]     in_best_data,
    input  logic                     in_hit_live,
    input  logic [DATA_BITS-1:0]     in_hit_data,
    input  logic [PRIORITY_BITS-1:0] in_hit_prio,
    output logic                     out_valid,
    output logic                     out_found,
    output logic [ID_BITS-1:0]       out_best_id,
    output logic [PRIORITY_BITS-1:0] out_best_prio,
    output logic [DATA_BITS-1:0]     out_best_data,
    output logic                     out_hit_live,
    output logic [DATA_BITS-1:0]     out_hit_data,
    output logic [PRIORITY_BITS-1:0] out_hit_prio
);

    localparam logic [ID_BITS-1:0]       MY_ID    = ID_BITS'(IDX);
    localparam logic [CNT_BITS-1:0]      MY_CNT   = CNT_BITS'(IDX);
    localparam logic [PRIORITY_BITS-1:0] PRIO_MAX = {PRIORITY_BITS{1'b1}};

    logic [DATA_BITS-1:0]     payload_reg, payload_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic                     popped_reg, popped_next;

    logic                     valid_reg;
    logic                     found_reg, found_next;
    logic [ID_BITS-1:0]       best_id_reg, best_id_next;
    logic [PRIORITY_BITS-1:0] best_prio_reg, best_prio_next;
    logic [DATA_BITS-1:0]     best_data_reg, best_data_next;
    logic                     hit_live_reg, hit_live_next;
    logic [DATA_BITS-1:0]     hit_data_reg, hit_data_next;
    logic [PRIORITY_BITS-1:0] hit_prio_reg, hit_prio_next;

    logic my_live;
    logic sel;
    logic [PRIORITY_BITS-1:0] prio_inc;

    assign my_live  = (MY_CNT < fill) && !popped_reg;
    assign sel      = (cmd_id == MY_ID);
    assign prio_inc = (prio_reg == PRIO_MAX) ? prio_reg : prio_reg + 1'b1;

    always_comb begin
        payload_next   = payload_reg;
        prio_next      = prio_reg;
        popped_next    = popped_reg;
        found_next     = in_found;
        best_id_next   = in_best_id;
        best_prio_next = in_best_prio;
        best_data_next = in_best_data;
        hit_live_next  = in_hit_live;
        hit_data_next  = in_hit_data;
        hit_prio_next  = in_hit_prio;
        if (in_valid) begin
            case (cmd_op) inside
                OP_ADD: begin
                    if (fill == MY_CNT) begin
                        payload_next = cmd_data;
                        prio_next    = '0;
                        popped_next  = 1'b0;
                    end
                end
                OP_PROMOTE: begin
                    if (sel && my_live) begin
                        prio_next     = prio_inc;
                        hit_live_next = 1'b1;
                        hit_prio_next = prio_inc;
                    end
                end
                OP_GET_MAX, OP_POP_MAX: begin
                    if (my_live && (!in_found || prio_reg >= in_best_prio)) begin
                        found_next     = 1'b1;
                        best_id_next   = MY_ID;
                        best_prio_next = prio_reg;
                        best_data_next = payload_reg;
                    end
                end
                OP_IS_VALID, OP_GET: begin
                    if (sel && my_live) begin
                        hit_live_next = 1'b1;
                        hit_data_next = payload_reg;
                    end
                end
                default: begin
                end
            endcase
        end
        if (retire_valid && retire_id == MY_ID) begin
            popped_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg   <= payload_next;
        prio_reg      <= prio_next;
        popped_reg    <= popped_next;
        found_reg     <= found_next;
        best_id_reg   <= best_id_next;
        best_prio_reg <= best_prio_next;
        best_data_reg <= best_data_next;
        hit_live_reg  <= hit_live_next;
        hit_data_reg  <= hit_data_next;
        hit_prio_reg  <= hit_prio_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid     = valid_reg;
    assign out_found     = found_reg;
    assign out_best_id   = best_id_reg;
    assign out_best_prio = best_prio_reg;
    assign out_best_data = best_data_reg;
    assign out_hit_live  = hit_live_reg;
    assign out_hit_data  = hit_data_reg;
    assign out_hit_prio  = hit_prio_reg;

endmodule

### dv/ptpm_reply_checker.sv
`timescale 1ns / 100ps

module ptpm_reply_checker
    import ptpm_pkg::*;
#(
    parameter int ENTRIES       = ENTRIES_DEF,
    parameter int DATA_BITS     = DATA_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    localparam int ID_BITS      = $clog2(ENTRIES)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [2:0]               s_opcode,
    input  logic [ID_BITS-1:0]       s_item_id,
    input  logic [DATA_BITS-1:0]     s_object_data,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [1:0]               m_status,
    input  logic [ID_BITS-1:0]       m_result_id,
    input  logic [DATA_BITS-1:0]     m_result_data,
    input  logic [PRIORITY_BITS-1:0] m_result_priority,
    input  logic                     m_id_live,
    output int                       n_errors,
    output int                       n_pending,
    output int                       n_replies,
    output int                       n_exhausted,
    output int                       n_saturated,
    output int                       n_empty
);

    typedef struct packed {
        logic [1:0]               status;
        logic [ID_BITS-1:0]       rid;
        logic [DATA_BITS-1:0]     rdata;
        logic [PRIORITY_BITS-1:0] rprio;
        logic                     live;
    } table_reply_t;

    table_reply_t             replies_due[$];
    logic [DATA_BITS-1:0]     payload_mem [ENTRIES];
    logic [PRIORITY_BITS-1:0] prio_mem [ENTRIES];
    bit                       live_map [ENTRIES];
    int                       next_id;
    int                       live_total;

    function automatic bit is_live(input logic [ID_BITS-1:0] id);
        return int'(id) < ENTRIES && live_map[id];
    endfunction

    function automatic table_reply_t predict_reply(input logic [2:0] op,
                                                   input logic [ID_BITS-1:0] id,
                                                   input logic [DATA_BITS-1:0] data);
        table_reply_t r;
        int best;
        r = '0;
        best = -1;
        case (op)
            OP_ADD: begin
                if (next_id >= ENTRIES) begin
                    r.status = ST_FULL;
                    n_exhausted++;
                end else begin
                    payload_mem[next_id] = data;
                    prio_mem[next_id] = '0;
                    live_map[next_id] = 1'b1;
                    r.rid = next_id[ID_BITS-1:0];
                    r.live = 1'b1;
                    next_id++;
                    live_total++;
                end
            end
            OP_PROMOTE: begin
                if (!is_live(id)) begin
                    r.status = ST_DEAD;
                end else begin
                    if (prio_mem[id] == '1) begin
                        n_saturated++;
                    end else begin
                        prio_mem[id] = prio_mem[id] + 1'b1;
                    end
                    r.rid = id;
                    r.rprio = prio_mem[id];
                    r.live = 1'b1;
                end
            end
            OP_GET_MAX, OP_POP_MAX: begin
                if (live_total == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (live_map[i] && (best < 0 || prio_mem[i] >= prio_mem[best])) begin
                            best = i;
                        end
                    end
                    r.rid = best[ID_BITS-1:0];
                    r.rdata = payload_mem[best];
                    r.rprio = prio_mem[best];
                    r.live = 1'b1;
                    if (op == OP_POP_MAX) begin
                        live_map[best] = 1'b0;
                        live_total--;
                        r.live = 1'b0;
                    end
                end
            end
            OP_IS_VALID: begin
                r.rid = id;
                r.live = is_live(id);
            end
            OP_GET: begin
                if (!is_live(id)) begin
                    r.status = ST_DEAD;
                end else begin
                    r.rid = id;
                    r.rdata = payload_mem[id];
                    r.live = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want_v,
                                   input logic [63:0] got_v);
        n_errors++;
        $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
    endtask

    always @(posedge aclk) begin : watch
        table_reply_t want;
        if (!aresetn) begin
            replies_due.delete();
            foreach (live_map[i]) live_map[i] = 1'b0;
            next_id = 0;
            live_total = 0;
            n_errors = 0;
            n_pending = 0;
            n_replies = 0;
            n_exhausted = 0;
            n_saturated = 0;
            n_empty = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    n_errors++;
                    $error("reply word arrived with no request outstanding");
                end else begin
                    want = replies_due.pop_front();
                    n_replies++;
                    if (m_status !== want.status) begin
                        report_mismatch("status", want.status, m_status);
                    end
                    if (m_result_id !== want.rid) begin
                        report_mismatch("result_id", want.rid, m_result_id);
                    end
                    if (m_result_data !== want.rdata) begin
                        report_mismatch("result_data", want.rdata, m_result_data);
                    end
                    if (m_result_priority !== want.rprio) begin
                        report_mismatch("result_priority", want.rprio, m_result_priority);
                    end
                    if (m_id_live !== want.live) begin
                        report_mismatch("id_live", want.live, m_id_live);
                    end
                end
            end
            if (s_valid && s_ready) begin
                replies_due.insert(replies_due.size(),
                                   predict_reply(s_opcode, s_item_id, s_object_data));
            end
            n_pending = replies_due.size();
        end
    end

endmodule

### dv/tb_priority_table_pop_max.sv
`timescale 1ns / 100ps

module tb_priority_table_pop_max;
    import ptpm_pkg::*;

    localparam int ENTRIES         = ENTRIES_DEF;
    localparam int DATA_BITS       = DATA_BITS_DEF;
    localparam int PRIO_BITS       = PRIORITY_BITS_DEF;
    localparam int ID_BITS         = $clog2(ENTRIES);
    localparam int WORDS_PER_PHASE = 460;
    localparam int LONG_HOLD       = 600;

    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [2:0]           s_opcode = '0;
    logic [ID_BITS-1:0]   s_item_id = '0;
    logic [DATA_BITS-1:0] s_object_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_status;
    logic [ID_BITS-1:0]   m_result_id;
    logic [DATA_BITS-1:0] m_result_data;
    logic [PRIO_BITS-1:0] m_result_priority;
    logic                 m_id_live;

    int n_errors;
    int n_pending;
    int n_replies;
    int n_exhausted;
    int n_saturated;
    int n_empty;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_due = 0;
    int hold_left = 0;
    int words_sent = 0;
    int adds_sent = 0;

    always #6 aclk = ~aclk;

    priority_table_pop_max #(
        .ENTRIES(ENTRIES),
        .DATA_BITS(DATA_BITS),
        .PRIORITY_BITS(PRIO_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_item_id(s_item_id),
        .s_object_data(s_object_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_result_id(m_result_id),
        .m_result_data(m_result_data),
        .m_result_priority(m_result_priority),
        .m_id_live(m_id_live)
    );

    ptpm_reply_checker #(
        .ENTRIES(ENTRIES),
        .DATA_BITS(DATA_BITS),
        .PRIORITY_BITS(PRIO_BITS)
    ) reply_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_item_id(s_item_id),
        .s_object_data(s_object_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_result_id(m_result_id),
        .m_result_data(m_result_data),
        .m_result_priority(m_result_priority),
        .m_id_live(m_id_live),
        .n_errors(n_errors),
        .n_pending(n_pending),
        .n_replies(n_replies),
        .n_exhausted(n_exhausted),
        .n_saturated(n_saturated),
        .n_empty(n_empty)
    );

    always @(posedge aclk) begin
        if (hold_due != 0) begin
            hold_due = 0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    task automatic send_word(input logic [2:0] op, input logic [ID_BITS-1:0] id,
                             input logic [DATA_BITS-1:0] data);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_item_id <= id;
        s_object_data <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (op == OP_ADD) begin
            adds_sent++;
        end
    endtask

    task automatic random_word();
        int pick;
        int hi;
        logic [ID_BITS-1:0] id;
        logic [2:0] op;
        pick = $urandom_range(0, 99);
        hi = (adds_sent >= ENTRIES) ? ENTRIES - 1 : adds_sent;
        if ($urandom_range(0, 9) == 0) begin
            id = ID_BITS'($urandom);
        end else begin
            id = ID_BITS'($urandom_range(0, hi));
        end
        if (pick < 14) begin
            op = OP_ADD;
        end else if (pick < 50) begin
            op = OP_PROMOTE;
        end else if (pick < 62) begin
            op = OP_GET_MAX;
        end else if (pick < 65) begin
            op = OP_POP_MAX;
        end else if (pick < 75) begin
            op = OP_IS_VALID;
        end else if (pick < 94) begin
            op = OP_GET;
        end else begin
            op = ($urandom_range(0, 1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
        end
        send_word(op, id, DATA_BITS'($urandom));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(OP_GET_MAX, '0, '0);
        send_word(OP_POP_MAX, '1, '1);
        send_word(OP_GET, '0, '0);
        send_word(OP_PROMOTE, '1, '0);
        send_word(OP_IS_VALID, '0, '0);
        send_word(OP_ADD, '0, '0);
        send_word(OP_ADD, '1, '1);
        repeat (8) send_word(OP_PROMOTE, '0, '0);
        send_word(OP_GET_MAX, '0, '0);
        send_word(OP_GET, ID_BITS'(1), '0);
        send_word(OP_IS_VALID, '1, '0);
        send_word(OP_UNUSED_6, '1, '1);
        send_word(OP_UNUSED_7, '0, '1);
        send_word(OP_POP_MAX, '0, '0);
        send_word(OP_PROMOTE, '0, '0);
        send_word(OP_ADD, '0, DATA_BITS'(32'h5a5a_a5a5));
        send_word(OP_GET_MAX, '0, '0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct = 70;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 70;
                    hold_due = 1;
                end
                default: begin
                    tx_idle_pct = 12;
                    rx_stall_pct = 12;
                end
            endcase
            repeat (WORDS_PER_PHASE) random_word();
        end

        s_valid <= 1'b0;
        rx_stall_pct = 0;
        @(negedge aclk);
        while (n_pending != 0) @(negedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);

        $display("Sent %0d words over four pacing phases, one with a %0d-cycle reply hold-off;",
                 words_sent, LONG_HOLD);
        $display("%0d replies compared: %0d exhausted adds, %0d saturated promotes, %0d empty.",
                 n_replies, n_exhausted, n_saturated, n_empty);
        if (n_errors == 0 && n_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
